// File: design/jsu_pkg.sv
`default_nettype none

package jsu_pkg;

  // Decoder phase
  typedef enum logic [2:0] {
    PH_IDLE,
    PH_BODY,
    PH_ESC,
    PH_HEX1,
    PH_HIGH,
    PH_HIGH_BS,
    PH_HEX2,
    PH_HALT
  } phase_t;

  // Result kinds
  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_END  = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  // Error codes
  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_NO_QUOTE  = 3'd1;
  localparam logic [2:0] ERR_NEWLINE   = 3'd2;
  localparam logic [2:0] ERR_UNT_ESC   = 3'd3;
  localparam logic [2:0] ERR_BAD_HEX   = 3'd4;
  localparam logic [2:0] ERR_BAD_PAIR  = 3'd5;
  localparam logic [2:0] ERR_UNK_ESC   = 3'd6;
  localparam logic [2:0] ERR_UNT_STR   = 3'd7;

  // Characters
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;

  // UTF-16 surrogate ranges and replacement
  localparam logic [15:0] SURR_HI_MIN = 16'hD800;
  localparam logic [15:0] SURR_HI_MAX = 16'hDBFF;
  localparam logic [15:0] SURR_LO_MIN = 16'hDC00;
  localparam logic [15:0] SURR_LO_MAX = 16'hDFFF;
  localparam logic [20:0] SUPP_BASE   = 21'h10000;
  localparam logic [20:0] CP_REPLACE  = 21'h00FFFD;

  localparam int MAX_RES = 4;
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);
  localparam int RCNT_W  = $clog2(MAX_RES + 1);
  localparam int RIDX_W  = $clog2(MAX_RES);

  typedef struct packed {
    logic [7:0] dbyte;
    logic [1:0] kind;
    logic [2:0] code;
  } res_t;

  // All words caused by one input byte
  typedef struct packed {
    logic [RCNT_W-1:0]      cnt;
    res_t [MAX_RES-1:0]     res;
  } bundle_t;

  function automatic res_t mk_data(logic [7:0] d);
    res_t r;
    r.dbyte = d;
    r.kind  = KIND_DATA;
    r.code  = ERR_NONE;
    return r;
  endfunction

  function automatic res_t mk_end();
    res_t r;
    r.dbyte = 8'h00;
    r.kind  = KIND_END;
    r.code  = ERR_NONE;
    return r;
  endfunction

  function automatic res_t mk_err(logic [2:0] code);
    res_t r;
    r.dbyte = 8'h00;
    r.kind  = KIND_ERR;
    r.code  = code;
    return r;
  endfunction

  function automatic bundle_t push(bundle_t b, res_t r);
    bundle_t o;
    o = b;
    if (b.cnt != RCNT_W'(MAX_RES)) begin
      o.res[b.cnt[RIDX_W-1:0]] = r;
      o.cnt = b.cnt + RCNT_W'(1);
    end
    return o;
  endfunction

  function automatic bundle_t push_utf8(bundle_t b, logic [20:0] cp);
    bundle_t o;
    o = b;
    if (cp < 21'h80) begin
      o = push(o, mk_data({1'b0, cp[6:0]}));
    end else if (cp < 21'h800) begin
      o = push(o, mk_data({3'b110, cp[10:6]}));
      o = push(o, mk_data({2'b10, cp[5:0]}));
    end else if (cp < 21'h10000) begin
      o = push(o, mk_data({4'b1110, cp[15:12]}));
      o = push(o, mk_data({2'b10, cp[11:6]}));
      o = push(o, mk_data({2'b10, cp[5:0]}));
    end else begin
      o = push(o, mk_data({5'b11110, cp[20:18]}));
      o = push(o, mk_data({2'b10, cp[17:12]}));
      o = push(o, mk_data({2'b10, cp[11:6]}));
      o = push(o, mk_data({2'b10, cp[5:0]}));
    end
    return o;
  endfunction

endpackage

`default_nettype wire

// File: design/jsu_front.sv
`default_nettype none

module jsu_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_byte,
  input  logic              end_of_text,
  input  logic              q_full,
  output logic              push_valid,
  output jsu_pkg::bundle_t  push_bundle
);

  jsu_pkg::phase_t phase, phase_next;
  logic [15:0]     first_unit, first_unit_next;
  logic [15:0]     second_unit, second_unit_next;
  logic [1:0]      digit_count, digit_count_next;

  logic            accept;
  logic            hx_ok;
  logic [3:0]      hx_val;
  logic            esc_hit;
  logic [7:0]      esc_val;
  logic [15:0]     first_shift, second_shift;
  logic            dc_done;
  logic            first_high, first_low, pair_ok;
  logic [20:0]     pair_cp;
  jsu_pkg::bundle_t bnd;

  function automatic logic [4:0] hex_digit(logic [7:0] c);
    logic [4:0] r;
    r = 5'b0;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
    return r;
  endfunction

  function automatic logic [8:0] esc_map(logic [7:0] c);
    logic [8:0] r;
    case (c)
      jsu_pkg::CH_QUOTE:  r = {1'b1, jsu_pkg::CH_QUOTE};
      jsu_pkg::CH_BSLASH: r = {1'b1, jsu_pkg::CH_BSLASH};
      jsu_pkg::CH_SLASH:  r = {1'b1, jsu_pkg::CH_SLASH};
      jsu_pkg::CH_B:      r = {1'b1, 8'h08};
      jsu_pkg::CH_F:      r = {1'b1, 8'h0C};
      jsu_pkg::CH_N:      r = {1'b1, 8'h0A};
      jsu_pkg::CH_R:      r = {1'b1, 8'h0D};
      jsu_pkg::CH_T:      r = {1'b1, 8'h09};
      default:            r = 9'b0;
    endcase
    return r;
  endfunction

  function automatic jsu_pkg::bundle_t body_res(jsu_pkg::bundle_t b, logic [7:0] c);
    jsu_pkg::bundle_t o;
    o = b;
    if (c == jsu_pkg::CH_QUOTE) o = jsu_pkg::push(b, jsu_pkg::mk_end());
    else if (c == jsu_pkg::CH_LF) o = jsu_pkg::push(b, jsu_pkg::mk_err(jsu_pkg::ERR_NEWLINE));
    else if (c != jsu_pkg::CH_BSLASH) o = jsu_pkg::push(b, jsu_pkg::mk_data(c));
    return o;
  endfunction

  function automatic jsu_pkg::phase_t body_next(logic [7:0] c);
    jsu_pkg::phase_t p;
    if (c == jsu_pkg::CH_QUOTE) p = jsu_pkg::PH_IDLE;
    else if (c == jsu_pkg::CH_LF) p = jsu_pkg::PH_HALT;
    else if (c == jsu_pkg::CH_BSLASH) p = jsu_pkg::PH_ESC;
    else p = jsu_pkg::PH_BODY;
    return p;
  endfunction

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  assign {hx_ok, hx_val}   = hex_digit(in_byte);
  assign {esc_hit, esc_val} = esc_map(in_byte);
  assign first_shift  = {first_unit[11:0], hx_val};
  assign second_shift = {second_unit[11:0], hx_val};
  assign dc_done      = digit_count == 2'd3;
  assign first_high   = first_shift >= jsu_pkg::SURR_HI_MIN && first_shift <= jsu_pkg::SURR_HI_MAX;
  assign first_low    = first_shift >= jsu_pkg::SURR_LO_MIN && first_shift <= jsu_pkg::SURR_LO_MAX;
  assign pair_ok      = second_shift >= jsu_pkg::SURR_LO_MIN
                        && second_shift <= jsu_pkg::SURR_LO_MAX
                        && first_unit >= jsu_pkg::SURR_HI_MIN
                        && first_unit <= jsu_pkg::SURR_HI_MAX;
  assign pair_cp      = jsu_pkg::SUPP_BASE + {1'b0, first_unit[9:0], second_shift[9:0]};

  // Next state
  always_comb begin
    phase_next       = phase;
    first_unit_next  = first_unit;
    second_unit_next = second_unit;
    digit_count_next = digit_count;
    if (accept) begin
      if (end_of_text) begin
        phase_next = jsu_pkg::PH_IDLE;
      end else begin
        case (phase)
          jsu_pkg::PH_IDLE: begin
            phase_next = (in_byte == jsu_pkg::CH_QUOTE) ? jsu_pkg::PH_BODY : jsu_pkg::PH_IDLE;
          end
          jsu_pkg::PH_BODY: phase_next = body_next(in_byte);
          jsu_pkg::PH_ESC, jsu_pkg::PH_HIGH_BS: begin
            if (esc_hit) begin
              phase_next = jsu_pkg::PH_BODY;
            end else if (in_byte == jsu_pkg::CH_U) begin
              digit_count_next = 2'd0;
              if (phase == jsu_pkg::PH_ESC) begin
                phase_next      = jsu_pkg::PH_HEX1;
                first_unit_next = 16'h0;
              end else begin
                phase_next       = jsu_pkg::PH_HEX2;
                second_unit_next = 16'h0;
              end
            end else begin
              phase_next = jsu_pkg::PH_HALT;
            end
          end
          jsu_pkg::PH_HEX1: begin
            if (!hx_ok) begin
              phase_next = jsu_pkg::PH_HALT;
            end else begin
              first_unit_next  = first_shift;
              digit_count_next = digit_count + 2'd1;
              if (dc_done) begin
                phase_next = first_high ? jsu_pkg::PH_HIGH : jsu_pkg::PH_BODY;
              end
            end
          end
          jsu_pkg::PH_HIGH: begin
            phase_next = (in_byte == jsu_pkg::CH_BSLASH) ? jsu_pkg::PH_HIGH_BS
                                                         : body_next(in_byte);
          end
          jsu_pkg::PH_HEX2: begin
            if (!hx_ok) begin
              phase_next = jsu_pkg::PH_HALT;
            end else begin
              second_unit_next = second_shift;
              digit_count_next = digit_count + 2'd1;
              if (dc_done) begin
                phase_next = pair_ok ? jsu_pkg::PH_BODY : jsu_pkg::PH_HALT;
              end
            end
          end
          jsu_pkg::PH_HALT: phase_next = jsu_pkg::PH_HALT;
          default:          phase_next = jsu_pkg::PH_IDLE;
        endcase
      end
    end
  end

  // Words caused by this byte
  always_comb begin
    bnd = '0;
    if (end_of_text) begin
      case (phase)
        jsu_pkg::PH_HALT: bnd = '0;
        jsu_pkg::PH_BODY: bnd = jsu_pkg::push(bnd, jsu_pkg::mk_err(jsu_pkg::ERR_UNT_STR));
        jsu_pkg::PH_ESC:  bnd = jsu_pkg::push(bnd, jsu_pkg::mk_err(jsu_pkg::ERR_UNT_ESC));
        jsu_pkg::PH_HEX1: bnd = jsu_pkg::push(bnd, jsu_pkg::mk_err(jsu_pkg::ERR_BAD_HEX));
        jsu_pkg::PH_HIGH: begin
          bnd = jsu_pkg::push_utf8(bnd, jsu_pkg::CP_REPLACE);
          bnd = jsu_pkg::push(bnd, jsu_pkg::mk_err(jsu_pkg::ERR_UNT_STR));
        end
        jsu_pkg::PH_HIGH_BS, jsu_pkg::PH_HEX2: begin
          bnd = jsu_pkg::push(bnd, jsu_pkg::mk_err(jsu_pkg::ERR_BAD_PAIR));
        end
        default: bnd = jsu_pkg::push(bnd, jsu_pkg::mk_err(jsu_pkg::ERR_NO_QUOTE));
      endcase
    end else begin
      case (phase)
        jsu_pkg::PH_IDLE: begin
          if (in_byte != jsu_pkg::CH_QUOTE) begin
            bnd = jsu_pkg::push(bnd, jsu_pkg::mk_err(jsu_pkg::ERR_NO_QUOTE));
          end
        end
        jsu_pkg::PH_BODY: bnd = body_res(bnd, in_byte);
        jsu_pkg::PH_ESC, jsu_pkg::PH_HIGH_BS: begin
          // after a high surrogate, anything but 'u' drops the pair
          if (phase == jsu_pkg::PH_HIGH_BS && in_byte != jsu_pkg::CH_U) begin
            bnd = jsu_pkg::push_utf8(bnd, jsu_pkg::CP_REPLACE);
          end
          if (esc_hit) begin
            bnd = jsu_pkg::push(bnd, jsu_pkg::mk_data(esc_val));
          end else if (in_byte != jsu_pkg::CH_U) begin
            bnd = jsu_pkg::push(bnd, jsu_pkg::mk_err(jsu_pkg::ERR_UNK_ESC));
          end
        end
        jsu_pkg::PH_HEX1: begin
          if (!hx_ok) begin
            bnd = jsu_pkg::push(bnd, jsu_pkg::mk_err(jsu_pkg::ERR_BAD_HEX));
          end else if (dc_done && !first_high) begin
            bnd = jsu_pkg::push_utf8(bnd, first_low ? jsu_pkg::CP_REPLACE
                                                    : {5'b0, first_shift});
          end
        end
        jsu_pkg::PH_HIGH: begin
          if (in_byte != jsu_pkg::CH_BSLASH) begin
            bnd = jsu_pkg::push_utf8(bnd, jsu_pkg::CP_REPLACE);
            bnd = body_res(bnd, in_byte);
          end
        end
        jsu_pkg::PH_HEX2: begin
          if (!hx_ok || (dc_done && !pair_ok)) begin
            bnd = jsu_pkg::push(bnd, jsu_pkg::mk_err(jsu_pkg::ERR_BAD_PAIR));
          end else if (dc_done) begin
            bnd = jsu_pkg::push_utf8(bnd, pair_cp);
          end
        end
        default: bnd = '0;
      endcase
    end
  end

  assign push_valid  = accept && (bnd.cnt != '0);
  assign push_bundle = bnd;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= jsu_pkg::PH_IDLE;
      first_unit  <= 16'h0;
      second_unit <= 16'h0;
      digit_count <= 2'd0;
    end else begin
      phase       <= phase_next;
      first_unit  <= first_unit_next;
      second_unit <= second_unit_next;
      digit_count <= digit_count_next;
    end
  end

endmodule

`default_nettype wire

// File: design/jsu_queue.sv
`default_nettype none

module jsu_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  input  jsu_pkg::bundle_t push_bundle,
  output logic             full,
  input  logic             pop_ready,
  output logic             pop_valid,
  output jsu_pkg::bundle_t pop_bundle
);

  jsu_pkg::bundle_t              slots [jsu_pkg::QDEPTH];
  logic [jsu_pkg::QPTR_W-1:0]    wr_ptr, rd_ptr;
  logic [jsu_pkg::QCNT_W-1:0]    count;
  logic                          do_push, do_pop;

  assign full       = count == jsu_pkg::QCNT_W'(jsu_pkg::QDEPTH);
  assign pop_valid  = count != '0;
  assign pop_bundle = slots[rd_ptr];
  assign do_push    = push_valid && !full;
  assign do_pop     = pop_ready && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_bundle;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + jsu_pkg::QPTR_W'(1);
      if (do_pop)  rd_ptr <= rd_ptr + jsu_pkg::QPTR_W'(1);
      if (do_push && !do_pop) count <= count + jsu_pkg::QCNT_W'(1);
      else if (do_pop && !do_push) count <= count - jsu_pkg::QCNT_W'(1);
    end
  end

endmodule

`default_nettype wire

// File: design/jsu_back.sv
`default_nettype none

module jsu_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             pop_valid,
  input  jsu_pkg::bundle_t pop_bundle,
  output logic             pop_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_byte,
  output logic [1:0]       result_kind,
  output logic [2:0]       error_code,
  output logic             last_of_run
);

  jsu_pkg::bundle_t             cur;
  logic                         cur_valid;
  logic [jsu_pkg::RIDX_W-1:0]   idx;
  jsu_pkg::res_t                sel;
  logic                         is_last;

  assign sel     = cur.res[idx];
  assign is_last = (jsu_pkg::RCNT_W'(idx) + jsu_pkg::RCNT_W'(1)) == cur.cnt;

  assign out_valid   = cur_valid;
  assign out_byte    = sel.dbyte;
  assign result_kind = sel.kind;
  assign error_code  = sel.code;
  assign last_of_run = is_last;

  // take the next bundle when none is held, or as the last word of the current one leaves
  assign pop_ready = !cur_valid || (out_ready && is_last);

  always_ff @(posedge clk) begin
    if (pop_ready && pop_valid) cur <= pop_bundle;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= '0;
    end else if (pop_ready) begin
      cur_valid <= pop_valid;
      idx       <= '0;
    end else if (out_ready) begin
      idx <= idx + jsu_pkg::RIDX_W'(1);
    end
  end

endmodule

`default_nettype wire

// File: design/json_string_unescape_unit.sv
// The first word of an item is written to a queue slot, then loaded into the output
// stage register, from which it is presented.
// Throughput: one byte per cycle while the queue is not full; the output side sends
// one word per cycle while out_ready is high, and a byte decodes to up to 4 words.
// A 4-entry queue of decoded bundles lets input run ahead of a stalled output.
// Reset (rst, synchronous): decoder returns to waiting for an opening quote;
// queue and output stage are emptied.
`default_nettype none

module json_string_unescape_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       end_of_text,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic [1:0] result_kind,
  output logic [2:0] error_code,
  output logic       last_of_run
);

  logic             q_full;
  logic             push_valid;
  jsu_pkg::bundle_t push_bundle;
  logic             pop_valid, pop_ready;
  jsu_pkg::bundle_t pop_bundle;

  jsu_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_byte     (in_byte),
    .end_of_text (end_of_text),
    .q_full      (q_full),
    .push_valid  (push_valid),
    .push_bundle (push_bundle)
  );

  jsu_queue u_queue (
    .clk         (clk),
    .rst         (rst),
    .push_valid  (push_valid),
    .push_bundle (push_bundle),
    .full        (q_full),
    .pop_ready   (pop_ready),
    .pop_valid   (pop_valid),
    .pop_bundle  (pop_bundle)
  );

  jsu_back u_back (
    .clk         (clk),
    .rst         (rst),
    .pop_valid   (pop_valid),
    .pop_bundle  (pop_bundle),
    .pop_ready   (pop_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .result_kind (result_kind),
    .error_code  (error_code),
    .last_of_run (last_of_run)
  );

endmodule

`default_nettype wire

// File: design/jsu_checker.sv
`default_nettype none

module jsu_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_ready,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] out_byte,
  input  logic [1:0] result_kind,
  input  logic [2:0] error_code,
  input  logic       last_of_run
);

  // come out of reset empty and ready for input
  a_reset_empty: assert property (@(posedge clk)
    rst |=> in_ready && !out_valid)
    else $error("not empty and ready after reset");

  // hold a stalled word
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte)
      && $stable(result_kind) && $stable(error_code) && $stable(last_of_run))
    else $error("output word changed while stalled");

  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> result_kind != 2'd3)
    else $error("undefined result kind");

  // end and error always close the run of one byte
  a_term_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind != jsu_pkg::KIND_DATA |-> last_of_run && out_byte == 8'h00)
    else $error("end or error word not last or carries data");

  a_code_match: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((result_kind == jsu_pkg::KIND_ERR) == (error_code != jsu_pkg::ERR_NONE)))
    else $error("error code does not match result kind");

endmodule

bind json_string_unescape_unit jsu_checker u_jsu_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_byte    (out_byte),
  .result_kind (result_kind),
  .error_code  (error_code),
  .last_of_run (last_of_run)
);

`default_nettype wire

// File: test/json_string_unescape_unit_tb.sv
`default_nettype none

module json_string_unescape_unit_tb;

  typedef struct {
    logic [7:0] data;
    logic       eot;
    int         mode;
    bit         drain;
  } text_item_t;

  typedef struct {
    logic [7:0] data;
    logic [1:0] kind;
    logic [2:0] code;
    logic       last;
  } out_word_t;

  // Traffic modes
  localparam int MODE_FREE   = 0;
  localparam int MODE_SEND   = 1;
  localparam int MODE_RECV   = 2;
  localparam int MODE_BOTH   = 3;
  localparam int MODE_SPAN   = 40;
  localparam int TOTAL_ITEMS = 320;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte = 8'h00;
  logic       end_of_text = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic [1:0] result_kind;
  logic [2:0] error_code;
  logic       last_of_run;

  json_string_unescape_unit u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_byte     (in_byte),
    .end_of_text (end_of_text),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .result_kind (result_kind),
    .error_code  (error_code),
    .last_of_run (last_of_run)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  text_item_t text_q[$];
  out_word_t  due_q[$];
  out_word_t  step_q[$];
  text_item_t next_item;
  out_word_t  want;
  int         fails = 0;
  int         gen_count = 0;
  int         cur_mode = MODE_FREE;
  bit         in_taken = 0;

  // Decoder state mirror
  jsu_pkg::phase_t ph = jsu_pkg::PH_IDLE;
  logic [15:0] unit1 = 16'h0000;
  logic [15:0] unit2 = 16'h0000;
  logic [2:0]  ndig = 3'd0;

  function automatic int hex_val(logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    return -1;
  endfunction

  function automatic bit is_esc_letter(logic [7:0] c);
    return c == jsu_pkg::CH_QUOTE || c == jsu_pkg::CH_BSLASH || c == jsu_pkg::CH_SLASH ||
           c == jsu_pkg::CH_B || c == jsu_pkg::CH_F || c == jsu_pkg::CH_N ||
           c == jsu_pkg::CH_R || c == jsu_pkg::CH_T;
  endfunction

  task automatic add_word(logic [1:0] kind, logic [7:0] data, logic [2:0] code);
    out_word_t w;
    w.data = data;
    w.kind = kind;
    w.code = code;
    w.last = 1'b0;
    if (step_q.size() < jsu_pkg::MAX_RES) step_q.push_back(w);
  endtask

  task automatic fail_with(logic [2:0] code);
    add_word(jsu_pkg::KIND_ERR, 8'h00, code);
    ph = jsu_pkg::PH_HALT;
  endtask

  task automatic add_data(logic [7:0] data);
    add_word(jsu_pkg::KIND_DATA, data, jsu_pkg::ERR_NONE);
  endtask

  task automatic add_utf8(logic [20:0] cp);
    if (cp < 21'h80) begin
      add_data(cp[7:0]);
    end else if (cp < 21'h800) begin
      add_data(8'hC0 | 8'(cp >> 6));
      add_data(8'h80 | 8'(cp & 21'h3F));
    end else if (cp < 21'h10000) begin
      add_data(8'hE0 | 8'(cp >> 12));
      add_data(8'h80 | 8'((cp >> 6) & 21'h3F));
      add_data(8'h80 | 8'(cp & 21'h3F));
    end else begin
      add_data(8'hF0 | 8'((cp >> 18) & 21'h07));
      add_data(8'h80 | 8'((cp >> 12) & 21'h3F));
      add_data(8'h80 | 8'((cp >> 6) & 21'h3F));
      add_data(8'h80 | 8'(cp & 21'h3F));
    end
  endtask

  task automatic body_char(logic [7:0] c);
    ph = jsu_pkg::PH_BODY;
    if (c == jsu_pkg::CH_QUOTE) begin
      add_word(jsu_pkg::KIND_END, 8'h00, jsu_pkg::ERR_NONE);
      ph = jsu_pkg::PH_IDLE;
    end else if (c == jsu_pkg::CH_LF) begin
      fail_with(jsu_pkg::ERR_NEWLINE);
    end else if (c == jsu_pkg::CH_BSLASH) begin
      ph = jsu_pkg::PH_ESC;
    end else begin
      add_data(c);
    end
  endtask

  task automatic esc_char(logic [7:0] c);
    ph = jsu_pkg::PH_BODY;
    case (c)
      jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH, jsu_pkg::CH_SLASH: add_data(c);
      jsu_pkg::CH_B: add_data(8'h08);
      jsu_pkg::CH_F: add_data(8'h0C);
      jsu_pkg::CH_N: add_data(8'h0A);
      jsu_pkg::CH_R: add_data(8'h0D);
      jsu_pkg::CH_T: add_data(8'h09);
      jsu_pkg::CH_U: begin
        ph = jsu_pkg::PH_HEX1;
        unit1 = 16'h0000;
        ndig = 3'd0;
      end
      default: fail_with(jsu_pkg::ERR_UNK_ESC);
    endcase
  endtask

  // Work out the words one accepted input byte causes
  task automatic decode_byte(logic [7:0] c, logic eot);
    int h;
    logic [20:0] cp;
    step_q.delete();
    if (eot) begin
      case (ph)
        jsu_pkg::PH_HALT: ;
        jsu_pkg::PH_BODY: add_word(jsu_pkg::KIND_ERR, 8'h00, jsu_pkg::ERR_UNT_STR);
        jsu_pkg::PH_ESC: add_word(jsu_pkg::KIND_ERR, 8'h00, jsu_pkg::ERR_UNT_ESC);
        jsu_pkg::PH_HEX1: add_word(jsu_pkg::KIND_ERR, 8'h00, jsu_pkg::ERR_BAD_HEX);
        jsu_pkg::PH_HIGH: begin
          add_utf8(jsu_pkg::CP_REPLACE);
          add_word(jsu_pkg::KIND_ERR, 8'h00, jsu_pkg::ERR_UNT_STR);
        end
        jsu_pkg::PH_HIGH_BS, jsu_pkg::PH_HEX2: begin
          add_word(jsu_pkg::KIND_ERR, 8'h00, jsu_pkg::ERR_BAD_PAIR);
        end
        default: add_word(jsu_pkg::KIND_ERR, 8'h00, jsu_pkg::ERR_NO_QUOTE);
      endcase
      ph = jsu_pkg::PH_IDLE;
    end else begin
      case (ph)
        jsu_pkg::PH_BODY: body_char(c);
        jsu_pkg::PH_ESC: esc_char(c);
        jsu_pkg::PH_HEX1: begin
          h = hex_val(c);
          if (h < 0) begin
            fail_with(jsu_pkg::ERR_BAD_HEX);
          end else begin
            unit1 = {unit1[11:0], 4'(h)};
            ndig = ndig + 3'd1;
            if (ndig >= 3'd4) begin
              ndig = 3'd0;
              if (unit1 >= jsu_pkg::SURR_HI_MIN && unit1 <= jsu_pkg::SURR_HI_MAX) begin
                ph = jsu_pkg::PH_HIGH;
              end else begin
                cp = 21'(unit1);
                if (unit1 >= jsu_pkg::SURR_LO_MIN && unit1 <= jsu_pkg::SURR_LO_MAX) begin
                  cp = jsu_pkg::CP_REPLACE;
                end
                add_utf8(cp);
                ph = jsu_pkg::PH_BODY;
              end
            end
          end
        end
        jsu_pkg::PH_HIGH: begin
          if (c == jsu_pkg::CH_BSLASH) begin
            ph = jsu_pkg::PH_HIGH_BS;
          end else begin
            add_utf8(jsu_pkg::CP_REPLACE);
            body_char(c);
          end
        end
        jsu_pkg::PH_HIGH_BS: begin
          if (c == jsu_pkg::CH_U) begin
            ph = jsu_pkg::PH_HEX2;
            unit2 = 16'h0000;
            ndig = 3'd0;
          end else begin
            add_utf8(jsu_pkg::CP_REPLACE);
            esc_char(c);
          end
        end
        jsu_pkg::PH_HEX2: begin
          h = hex_val(c);
          if (h < 0) begin
            fail_with(jsu_pkg::ERR_BAD_PAIR);
          end else begin
            unit2 = {unit2[11:0], 4'(h)};
            ndig = ndig + 3'd1;
            if (ndig >= 3'd4) begin
              ndig = 3'd0;
              if (unit2 < jsu_pkg::SURR_LO_MIN || unit2 > jsu_pkg::SURR_LO_MAX ||
                  unit1 < jsu_pkg::SURR_HI_MIN || unit1 > jsu_pkg::SURR_HI_MAX) begin
                fail_with(jsu_pkg::ERR_BAD_PAIR);
              end else begin
                cp = jsu_pkg::SUPP_BASE + (21'(unit1 - jsu_pkg::SURR_HI_MIN) << 10) +
                     21'(unit2 - jsu_pkg::SURR_LO_MIN);
                add_utf8(cp);
                ph = jsu_pkg::PH_BODY;
              end
            end
          end
        end
        jsu_pkg::PH_HALT: ;
        default: begin
          if (c == jsu_pkg::CH_QUOTE) begin
            ph = jsu_pkg::PH_BODY;
          end else begin
            add_word(jsu_pkg::KIND_ERR, 8'h00, jsu_pkg::ERR_NO_QUOTE);
            ph = jsu_pkg::PH_IDLE;
          end
        end
      endcase
    end
    if (step_q.size() > 0) step_q[step_q.size() - 1].last = 1'b1;
    foreach (step_q[i]) due_q.push_back(step_q[i]);
  endtask

  // Stimulus helpers
  task automatic put(logic [7:0] data, logic eot);
    text_item_t t;
    t.data = data;
    t.eot = eot;
    t.mode = (gen_count / MODE_SPAN) % 4;
    // pause for a full drain whenever the traffic mode changes
    t.drain = (gen_count > 0) && (gen_count % MODE_SPAN == 0);
    text_q.push_back(t);
    gen_count++;
  endtask

  task automatic put_eot();
    put(8'($urandom_range(0, 255)), 1'b1);
  endtask

  function automatic logic [7:0] hex_char(logic [3:0] nib);
    if (nib < 4'd10) return 8'("0") + 8'(nib);
    if ($urandom_range(0, 1)) return 8'("a") + 8'(nib) - 8'd10;
    return 8'("A") + 8'(nib) - 8'd10;
  endfunction

  task automatic put_hex4(logic [15:0] v);
    for (int i = 3; i >= 0; i--) put(hex_char(v[4*i +: 4]), 1'b0);
  endtask

  task automatic put_digits(int n);
    for (int i = 0; i < n; i++) put(hex_char(4'($urandom_range(0, 15))), 1'b0);
  endtask

  task automatic put_u();
    put(jsu_pkg::CH_BSLASH, 1'b0);
    put(jsu_pkg::CH_U, 1'b0);
  endtask

  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (c == jsu_pkg::CH_QUOTE || c == jsu_pkg::CH_BSLASH || c == jsu_pkg::CH_LF);
    return c;
  endfunction

  function automatic logic [7:0] non_hex_char();
    logic [7:0] c;
    if ($urandom_range(0, 4) == 0) return jsu_pkg::CH_LF;
    do c = 8'($urandom_range(0, 255));
    while (hex_val(c) >= 0);
    return c;
  endfunction

  function automatic logic [7:0] esc_letter();
    case ($urandom_range(0, 7))
      0: return jsu_pkg::CH_QUOTE;
      1: return jsu_pkg::CH_BSLASH;
      2: return jsu_pkg::CH_SLASH;
      3: return jsu_pkg::CH_B;
      4: return jsu_pkg::CH_F;
      5: return jsu_pkg::CH_N;
      6: return jsu_pkg::CH_R;
      default: return jsu_pkg::CH_T;
    endcase
  endfunction

  function automatic logic [7:0] bad_letter();
    logic [7:0] c;
    if ($urandom_range(0, 3) == 0) return jsu_pkg::CH_LF;
    do c = 8'($urandom_range(0, 255));
    while (is_esc_letter(c) || c == jsu_pkg::CH_U);
    return c;
  endfunction

  function automatic logic [15:0] high_unit();
    return 16'($urandom_range(jsu_pkg::SURR_HI_MIN, jsu_pkg::SURR_HI_MAX));
  endfunction

  function automatic logic [15:0] low_unit();
    return 16'($urandom_range(jsu_pkg::SURR_LO_MIN, jsu_pkg::SURR_LO_MAX));
  endfunction

  // One quoted string, mostly well formed, with random content
  task automatic gen_string();
    int npieces, sel, n;
    bit dead, closed;
    logic [7:0] c;
    logic [15:0] v;
    dead = 0;
    closed = 0;
    if ($urandom_range(0, 19) == 0) begin
      do c = 8'($urandom_range(0, 255));
      while (c == jsu_pkg::CH_QUOTE);
      put(c, 1'b0);
    end
    put(jsu_pkg::CH_QUOTE, 1'b0);
    npieces = $urandom_range(0, 8);
    for (int k = 0; k < npieces && !dead && !closed; k++) begin
      sel = $urandom_range(0, 99);
      if (sel < 35) begin
        put(plain_char(), 1'b0);
      end else if (sel < 55) begin
        put(jsu_pkg::CH_BSLASH, 1'b0);
        put(esc_letter(), 1'b0);
      end else if (sel < 65) begin
        case ($urandom_range(0, 2))
          0: v = 16'($urandom_range(0, 'h7F));
          1: v = 16'($urandom_range('h80, 'h7FF));
          default: v = 16'($urandom_range(0, 'hFFFF));
        endcase
        // a high surrogate here would pull in the next piece as a pair
        if (v >= jsu_pkg::SURR_HI_MIN && v <= jsu_pkg::SURR_HI_MAX) v = v ^ 16'h4000;
        put_u();
        put_hex4(v);
      end else if (sel < 75) begin
        put_u();
        put_hex4(high_unit());
        put_u();
        put_hex4(low_unit());
      end else if (sel < 80) begin
        put_u();
        put_hex4(low_unit());
      end else if (sel < 84) begin
        put_u();
        put_hex4(high_unit());
        if ($urandom_range(0, 3) == 0) begin
          put(jsu_pkg::CH_QUOTE, 1'b0);
          closed = 1;
        end else begin
          put(plain_char(), 1'b0);
        end
      end else if (sel < 87) begin
        put_u();
        put_hex4(high_unit());
        put(jsu_pkg::CH_BSLASH, 1'b0);
        c = ($urandom_range(0, 9) < 6) ? esc_letter() : bad_letter();
        put(c, 1'b0);
        dead = !is_esc_letter(c);
      end else if (sel < 90) begin
        put_u();
        put_hex4(high_unit());
        put_u();
        if ($urandom_range(0, 1)) begin
          put_digits($urandom_range(0, 3));
          put(non_hex_char(), 1'b0);
        end else if ($urandom_range(0, 1)) begin
          put_hex4(16'($urandom_range(0, jsu_pkg::SURR_LO_MIN - 1)));
        end else begin
          put_hex4(16'($urandom_range(jsu_pkg::SURR_LO_MAX + 1, 'hFFFF)));
        end
        dead = 1;
      end else if (sel < 93) begin
        put_u();
        put_digits($urandom_range(0, 3));
        put(non_hex_char(), 1'b0);
        dead = 1;
      end else if (sel < 96) begin
        put(jsu_pkg::CH_BSLASH, 1'b0);
        put(bad_letter(), 1'b0);
        dead = 1;
      end else begin
        put(jsu_pkg::CH_LF, 1'b0);
        dead = 1;
      end
    end
    if (dead) begin
      // halted: these bytes are dropped until end of text
      n = $urandom_range(0, 2);
      for (int i = 0; i < n; i++) put(8'($urandom_range(0, 255)), 1'b0);
      put_eot();
    end else if (!closed) begin
      sel = $urandom_range(0, 9);
      if (sel < 7) begin
        put(jsu_pkg::CH_QUOTE, 1'b0);
      end else if (sel < 8) begin
        put_eot();
      end else begin
        case ($urandom_range(0, 4))
          0: put(jsu_pkg::CH_BSLASH, 1'b0);
          1: begin
            put_u();
            put_digits($urandom_range(0, 3));
          end
          2: begin
            put_u();
            put_hex4(high_unit());
          end
          3: begin
            put_u();
            put_hex4(high_unit());
            put(jsu_pkg::CH_BSLASH, 1'b0);
          end
          default: begin
            put_u();
            put_hex4(high_unit());
            put_u();
            put_digits($urandom_range(0, 3));
          end
        endcase
        put_eot();
      end
    end
  endtask

  // Driver: present the next input byte at the falling edge, hold until accepted
  always @(negedge clk) begin
    if (!rst) begin
      case (cur_mode)
        MODE_RECV: out_ready <= ($urandom_range(0, 99) >= 87);
        MODE_BOTH: out_ready <= ($urandom_range(0, 99) >= 18);
        default:   out_ready <= 1'b1;
      endcase
      if (!in_valid || in_taken) begin
        in_taken = 0;
        if (text_q.size() > 0 && !(text_q[0].drain && due_q.size() != 0) &&
            !(cur_mode == MODE_SEND && $urandom_range(0, 99) < 87) &&
            !(cur_mode == MODE_BOTH && $urandom_range(0, 99) < 18)) begin
          next_item = text_q.pop_front();
          cur_mode = next_item.mode;
          in_valid <= 1'b1;
          in_byte <= next_item.data;
          end_of_text <= next_item.eot;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: predict on input acceptance, compare each result word
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        decode_byte(in_byte, end_of_text);
        in_taken = 1;
      end
      if (out_valid && out_ready) begin
        if (due_q.size() == 0) begin
          $error("unexpected result word: out_byte %h result_kind %0d error_code %0d",
                 out_byte, result_kind, error_code);
          fails++;
        end else begin
          want = due_q.pop_front();
          if (out_byte !== want.data) begin
            $error("out_byte: expected %h, actual %h", want.data, out_byte);
            fails++;
          end
          if (result_kind !== want.kind) begin
            $error("result_kind: expected %0d, actual %0d", want.kind, result_kind);
            fails++;
          end
          if (error_code !== want.code) begin
            $error("error_code: expected %0d, actual %0d", want.code, error_code);
            fails++;
          end
          if (last_of_run !== want.last) begin
            $error("last_of_run: expected %0d, actual %0d", want.last, last_of_run);
            fails++;
          end
        end
      end
    end
  end

  initial begin
    // directed: idle errors, byte extremes, escape, pair, zero code point, newline
    put("x", 1'b0);
    put_eot();
    put(jsu_pkg::CH_QUOTE, 1'b0);
    put(8'hFF, 1'b0);
    put(8'h01, 1'b0);
    put(jsu_pkg::CH_BSLASH, 1'b0);
    put(jsu_pkg::CH_QUOTE, 1'b0);
    put_u();
    put_hex4(16'hDBFF);
    put_u();
    put_hex4(16'hDFFF);
    put(jsu_pkg::CH_QUOTE, 1'b0);
    put(jsu_pkg::CH_QUOTE, 1'b0);
    put_u();
    put_hex4(16'h0000);
    put(jsu_pkg::CH_LF, 1'b0);
    put_eot();
    while (gen_count < TOTAL_ITEMS) gen_string();

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (text_q.size() != 0 || in_valid) @(posedge clk);
    while (due_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fails == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

`default_nettype wire
